### design/fcm_pkg.sv
// Shared types, constants and register indexes for the false-color pixel mapper.
package fcm_pkg;

  localparam int unsigned SAMPLE_BITS_DEF = 16;
  localparam int unsigned IN_W            = 16;
  localparam int unsigned CFG_W           = 16;
  localparam int unsigned CFG_IDX_W       = 2;
  localparam int unsigned QUO_BITS        = 11;
  localparam int unsigned CH_W            = 8;

  localparam logic [QUO_BITS-1:0] K_RAINBOW = QUO_BITS'(1280);
  localparam logic [QUO_BITS-1:0] K_CIRCLE  = QUO_BITS'(1536);
  localparam logic [QUO_BITS-1:0] K_GRAY    = QUO_BITS'(255);

  localparam logic [CH_W-1:0] CH_MAX = {CH_W{1'b1}};
  localparam logic [CH_W-1:0] CH_MIN = '0;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_LOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_HIGH = 2'd2;

  typedef enum logic [1:0] {
    MODE_RAINBOW  = 2'd0,
    MODE_CIRCLE   = 2'd1,
    MODE_GRAY     = 2'd2,
    MODE_GRAY_INV = 2'd3
  } mode_t;

  typedef struct packed {
    mode_t mode;
    logic  blank;
    logic  top;
    logic  above;
  } ctl_t;

endpackage

### design/false_color_map_pixel_unit.sv
// Top level of the false-color pixel mapper: range check, scaling, divider and color lookup.
//
//  Channel | Ports                                       | Direction
//  --------+---------------------------------------------+----------
//  in      | in_valid, in_stall, in_sample               | sample in
//  out     | out_valid, out_stall, out_red/green/blue,   | pixel out
//          | out_out_of_range                            |
//  cfg     | cfg_wr_en, cfg_index, cfg_wdata             | writes in
//
// One transaction is taken per clock while in_stall is low.
// The divider resolves one quotient bit per stage.
// Reset is synchronous; it clears the valid bits, mode and low, and sets high to all ones.
// Every stage holds its transaction while the next one is full, so bubbles close up.
module false_color_map_pixel_unit import fcm_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [IN_W-1:0]      in_sample,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [CH_W-1:0]      out_red,
  output logic [CH_W-1:0]      out_green,
  output logic [CH_W-1:0]      out_blue,
  output logic                 out_out_of_range
);

  localparam int unsigned DW = (SAMPLE_BITS < IN_W) ? SAMPLE_BITS : IN_W;
  localparam int unsigned QB = QUO_BITS;
  localparam int unsigned NW = DW + QB;

  mode_t         mode_r;
  logic [DW-1:0] low_r;
  logic [DW-1:0] high_r;
  logic [DW-1:0] span_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_RAINBOW;
      low_r  <= '0;
      high_r <= '1;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_IDX_MODE: mode_r <= mode_t'(cfg_wdata[1:0]);
        CFG_IDX_LOW:  low_r  <= cfg_wdata[DW-1:0];
        CFG_IDX_HIGH: high_r <= cfg_wdata[DW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    span_r <= high_r - low_r;
  end

  logic rdy_a;
  logic rdy_b;
  logic rdy_c;
  logic rdy_out;
  logic div_in_ready;

  // Stage A: registered sample.
  logic          v_a_r;
  logic [DW-1:0] smp_a_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_a_r <= 1'b0;
    end else if (rdy_a) begin
      v_a_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_a && in_valid) begin
      smp_a_r <= in_sample[DW-1:0];
    end
  end

  ctl_t             ctl_a;
  logic [DW-1:0]    opnd_a;
  logic [QB-1:0]    k_a;

  always_comb begin
    ctl_a.mode  = mode_r;
    ctl_a.blank = (high_r <= low_r) || (smp_a_r < low_r);
    ctl_a.top   = (smp_a_r >= high_r);
    ctl_a.above = (smp_a_r > high_r);
    opnd_a      = (mode_r == MODE_GRAY_INV) ? (high_r - smp_a_r) : (smp_a_r - low_r);
    case (mode_r)
      MODE_RAINBOW: k_a = K_RAINBOW;
      MODE_CIRCLE:  k_a = K_CIRCLE;
      default:      k_a = K_GRAY;
    endcase
  end

  // Stage B: operand and scale factor.
  logic          v_b_r;
  logic [DW-1:0] opnd_b_r;
  logic [QB-1:0] k_b_r;
  ctl_t          ctl_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_b_r <= 1'b0;
    end else if (rdy_b) begin
      v_b_r <= v_a_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_b && v_a_r) begin
      opnd_b_r <= opnd_a;
      k_b_r    <= k_a;
      ctl_b_r  <= ctl_a;
    end
  end

  // Stage C: scaled numerator.
  logic          v_c_r;
  logic [NW-1:0] num_c_r;
  ctl_t          ctl_c_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_c_r <= 1'b0;
    end else if (rdy_c) begin
      v_c_r <= v_b_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_c && v_b_r) begin
      num_c_r <= NW'(opnd_b_r) * NW'(k_b_r);
      ctl_c_r <= ctl_b_r;
    end
  end

  assign rdy_c = !v_c_r || div_in_ready;
  assign rdy_b = !v_b_r || rdy_c;
  assign rdy_a = !v_a_r || rdy_b;
  assign in_stall = !rdy_a;

  logic          div_vld;
  logic [QB-1:0] div_quo;
  ctl_t          div_ctl;

  fcm_divider #(
    .DW(DW),
    .QB(QB)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .span      (span_r),
    .in_valid  (v_c_r),
    .in_ready  (div_in_ready),
    .in_num    (num_c_r),
    .in_ctl    (ctl_c_r),
    .out_valid (div_vld),
    .out_ready (rdy_out),
    .out_quo   (div_quo),
    .out_ctl   (div_ctl)
  );

  // Color lookup and output register.
  logic [CH_W-1:0] r_nxt;
  logic [CH_W-1:0] g_nxt;
  logic [CH_W-1:0] b_nxt;
  logic            flag_nxt;
  logic [CH_W-1:0] frac;
  logic [CH_W-1:0] frac_inv;
  logic [2:0]      seg;

  always_comb begin
    frac     = div_quo[CH_W-1:0];
    frac_inv = CH_MAX - frac;
    seg      = div_quo[QB-1:CH_W];
    r_nxt    = CH_MIN;
    g_nxt    = CH_MIN;
    b_nxt    = CH_MIN;
    flag_nxt = 1'b0;
    if (div_ctl.blank) begin
      flag_nxt = 1'b1;
    end else if (div_ctl.top) begin
      flag_nxt = div_ctl.above;
      case (div_ctl.mode)
        MODE_RAINBOW: begin
          r_nxt = div_ctl.above ? CH_MIN : CH_MAX;
        end
        MODE_CIRCLE: begin
          r_nxt = CH_MAX;
          b_nxt = CH_MAX;
        end
        MODE_GRAY: begin
          r_nxt = CH_MAX;
          g_nxt = CH_MAX;
          b_nxt = CH_MAX;
        end
        default: ;
      endcase
    end else if (div_ctl.mode == MODE_GRAY || div_ctl.mode == MODE_GRAY_INV) begin
      r_nxt = frac;
      g_nxt = frac;
      b_nxt = frac;
    end else begin
      case (seg)
        3'd0: begin
          r_nxt = frac_inv;
          b_nxt = CH_MAX;
        end
        3'd1: begin
          g_nxt = frac;
          b_nxt = CH_MAX;
        end
        3'd2: begin
          g_nxt = CH_MAX;
          b_nxt = frac_inv;
        end
        3'd3: begin
          r_nxt = frac;
          g_nxt = CH_MAX;
        end
        3'd4: begin
          r_nxt = CH_MAX;
          g_nxt = frac_inv;
        end
        default: begin
          r_nxt = CH_MAX;
          b_nxt = frac;
        end
      endcase
    end
  end

  logic            out_valid_r;
  logic [CH_W-1:0] out_red_r;
  logic [CH_W-1:0] out_green_r;
  logic [CH_W-1:0] out_blue_r;
  logic            out_flag_r;

  assign rdy_out = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (rdy_out) begin
      out_valid_r <= div_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_out && div_vld) begin
      out_red_r   <= r_nxt;
      out_green_r <= g_nxt;
      out_blue_r  <= b_nxt;
      out_flag_r  <= flag_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_red          = out_red_r;
  assign out_green        = out_green_r;
  assign out_blue         = out_blue_r;
  assign out_out_of_range = out_flag_r;

  // A gray pixel always has equal channels.
  a_gray_equal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (mode_r == MODE_GRAY || mode_r == MODE_GRAY_INV)
    |-> (out_red_r == out_green_r) && (out_green_r == out_blue_r))
    else $error("gray pixel with unequal channels");

  // An in-range hue pixel has one channel at full scale and one at zero.
  a_hue_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_flag_r && (mode_r == MODE_RAINBOW || mode_r == MODE_CIRCLE)
    |-> (out_red_r == CH_MAX || out_green_r == CH_MAX || out_blue_r == CH_MAX) &&
        (out_red_r == CH_MIN || out_green_r == CH_MIN || out_blue_r == CH_MIN))
    else $error("hue pixel off the color wheel");

  // An empty range yields flagged black.
  a_empty_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (high_r <= low_r)
    |-> out_flag_r && out_red_r == CH_MIN && out_green_r == CH_MIN && out_blue_r == CH_MIN)
    else $error("empty range did not give flagged black");

endmodule

### design/fcm_divider.sv
// Pipelined restoring divider, one quotient bit per stage, with side-band control.
module fcm_divider import fcm_pkg::*; #(
  parameter int unsigned DW = SAMPLE_BITS_DEF,
  parameter int unsigned QB = QUO_BITS
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [DW-1:0]    span,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [DW+QB-1:0] in_num,
  input  ctl_t             in_ctl,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [QB-1:0]    out_quo,
  output ctl_t             out_ctl
);

  localparam int unsigned NW = DW + QB;

  logic [DW-1:0] st_rem [QB];
  logic [QB-1:0] st_lo  [QB];
  logic [QB-1:0] st_quo [QB];
  ctl_t          st_ctl [QB];
  logic          st_vld [QB];
  logic          rdy    [QB+1];

  assign rdy[QB] = out_ready;

  for (genvar j = 0; j < QB; j++) begin : g_step
    logic [DW-1:0] src_rem;
    logic [QB-1:0] src_lo;
    logic [QB-1:0] src_quo;
    ctl_t          src_ctl;
    logic          src_vld;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;
    logic [DW-1:0] rem_r;
    logic [QB-1:0] lo_r;
    logic [QB-1:0] quo_r;
    ctl_t          ctl_r;
    logic          vld_r;

    if (j == 0) begin : g_first
      assign src_rem = in_num[NW-1:QB];
      assign src_lo  = in_num[QB-1:0];
      assign src_quo = '0;
      assign src_ctl = in_ctl;
      assign src_vld = in_valid;
    end else begin : g_next
      assign src_rem = st_rem[j-1];
      assign src_lo  = st_lo[j-1];
      assign src_quo = st_quo[j-1];
      assign src_ctl = st_ctl[j-1];
      assign src_vld = st_vld[j-1];
    end

    assign trial = {src_rem, src_lo[QB-1]};
    assign diff  = trial - {1'b0, span};
    assign ge    = (trial >= {1'b0, span});
    assign rdy[j] = !vld_r || rdy[j+1];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r <= 1'b0;
      end else if (rdy[j]) begin
        vld_r <= src_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[j] && src_vld) begin
        rem_r <= ge ? diff[DW-1:0] : trial[DW-1:0];
        lo_r  <= {src_lo[QB-2:0], 1'b0};
        quo_r <= {src_quo[QB-2:0], ge};
        ctl_r <= src_ctl;
      end
    end

    assign st_rem[j] = rem_r;
    assign st_lo[j]  = lo_r;
    assign st_quo[j] = quo_r;
    assign st_ctl[j] = ctl_r;
    assign st_vld[j] = vld_r;
  end

  assign in_ready  = rdy[0];
  assign out_valid = st_vld[QB-1];
  assign out_quo   = st_quo[QB-1];
  assign out_ctl   = st_ctl[QB-1];

endmodule
